// ===== hw/rtl/utdd_pkg.sv =====
// Shared types and constant tables of the Unix time to DOS date/time converter.
// Depends on nothing; the core and utdd_date_pipe import it.
package utdd_pkg;

  localparam int unsigned DaysW = 19;
  localparam int unsigned YearW = 12;

  localparam logic [YearW-1:0] DosYearBase = 12'd1980;

  typedef logic [DaysW-1:0] days_t;

  typedef struct packed {
    logic [YearW-1:0] year;
    logic [3:0]       month;
    logic [4:0]       day;
  } date_t;

  // First shifted day number of each 400-year era.
  function automatic logic [20:0] era_base(input logic [2:0] era);
    logic [20:0] base;
    case (era)
      3'd0:    base = 21'd0;
      3'd1:    base = 21'd146097;
      3'd2:    base = 21'd292194;
      3'd3:    base = 21'd438291;
      3'd4:    base = 21'd584388;
      3'd5:    base = 21'd730485;
      3'd6:    base = 21'd876582;
      3'd7:    base = 21'd1022679;
      default: base = 21'd0;
    endcase
    return base;
  endfunction

  // Day of the March-based year on which each month starts.
  function automatic logic [8:0] month_offset(input logic [3:0] mp);
    logic [8:0] off;
    case (mp)
      4'd0:    off = 9'd0;
      4'd1:    off = 9'd31;
      4'd2:    off = 9'd61;
      4'd3:    off = 9'd92;
      4'd4:    off = 9'd122;
      4'd5:    off = 9'd153;
      4'd6:    off = 9'd184;
      4'd7:    off = 9'd214;
      4'd8:    off = 9'd245;
      4'd9:    off = 9'd275;
      4'd10:   off = 9'd306;
      4'd11:   off = 9'd337;
      default: off = 9'd0;
    endcase
    return off;
  endfunction

endpackage

// ===== hw/rtl/utdd_in_if.sv =====
// Input channel of the converter: valid/ready handshake with the timestamp pair.
// Depends on nothing.
interface utdd_in_if;
  logic               valid;
  logic               ready;
  logic signed [35:0] unix_seconds;
  logic        [34:0] now_seconds;

  modport source (output valid, output unix_seconds, output now_seconds, input ready);
  modport sink (input valid, input unix_seconds, input now_seconds, output ready);
endinterface

// ===== hw/rtl/utdd_out_if.sv =====
// Output channel of the converter: valid/ready handshake with the packed DOS words.
// Depends on nothing.
interface utdd_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] dos_date;
  logic [15:0] dos_time;

  modport source (output valid, output dos_date, output dos_time, input ready);
  modport sink (input valid, input dos_date, input dos_time, output ready);
endinterface

// ===== hw/rtl/unix_time_to_dos_datetime_core.sv =====
// Converts a signed Unix timestamp, or the current time when the timestamp is not
// positive, into the packed MS-DOS date and time words in UTC; dates before 1980
// read as 1980-01-01 00:00:00. The block is a ten-stage pipeline that takes one
// transaction per cycle for as long as the output side takes them; when the output
// is held back the whole pipeline holds. Depends on utdd_pkg, utdd_in_if,
// utdd_out_if and utdd_date_pipe.
module unix_time_to_dos_datetime_core import utdd_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  utdd_in_if.sink   in_i,
  utdd_out_if.source out_o
);

  localparam int unsigned NumStages = 10;
  localparam logic [28:0] DayRecip  = 29'd407226528;

  logic [NumStages-1:0] valid_q;
  logic                 advance;

  logic        use_ts;
  logic [34:0] t1_d;
  logic [34:0] t1_q;

  logic [56:0] day_prod;
  logic [18:0] q2_q;
  logic [34:0] t2_q;

  logic [27:0] rem_hi;
  logic [9:0]  rem_lo;
  days_t       days3_d;
  days_t       days3_q;
  logic [16:0] sod3_q;

  logic [26:0] hour_prod;
  logic [4:0]  hour4_q;
  logic [16:0] sod4_q;

  logic [11:0] rem5_d;
  logic [11:0] rem5_q;
  logic [4:0]  hour5_q;

  logic [20:0] min_prod;
  logic [5:0]  min6_q;
  logic [11:0] rem6_q;
  logic [4:0]  hour6_q;

  logic [5:0]  sec7;
  logic [15:0] time7_q;
  logic [15:0] time8_q;
  logic [15:0] time9_q;

  date_t       date9;
  logic [11:0] year_ofs;
  logic [15:0] dos_date_d;
  logic [15:0] dos_time_d;
  logic [15:0] dos_date_q;
  logic [15:0] dos_time_q;

  assign advance    = ~valid_q[NumStages-1] | out_o.ready;
  assign in_i.ready = advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (advance) begin
      valid_q <= {valid_q[NumStages-2:0], in_i.valid};
    end
  end

  assign use_ts = ~in_i.unix_seconds[35] & (in_i.unix_seconds != '0);
  assign t1_d   = use_ts ? in_i.unix_seconds[34:0] : in_i.now_seconds;

  assign day_prod = 57'(t1_q[34:7]) * 57'(DayRecip);

  always_comb begin
    rem_hi  = t2_q[34:7] - 28'(28'(q2_q) * 28'd675);
    days3_d = q2_q;
    rem_lo  = rem_hi[9:0];
    if (rem_hi >= 28'd675) begin
      days3_d = q2_q + 19'd1;
      rem_lo  = 10'(rem_hi - 28'd675);
    end
  end

  assign hour_prod = 27'(sod3_q[16:4]) * 27'd9321;
  assign rem5_d    = 12'(sod4_q - 17'(17'(hour4_q) * 17'd3600));
  assign min_prod  = 21'(rem5_q[11:2]) * 21'd1093;
  assign sec7      = 6'(rem6_q - 12'(12'(min6_q) * 12'd60));

  utdd_date_pipe u_date_pipe (
    .clk_i  (clk_i),
    .en_i   (advance),
    .days_i (days3_q),
    .date_o (date9)
  );

  always_comb begin
    year_ofs = date9.year - DosYearBase;
    if (date9.year < DosYearBase) begin
      dos_date_d = 16'h0021;
      dos_time_d = '0;
    end else begin
      dos_date_d = {year_ofs[6:0], date9.month, date9.day};
      dos_time_d = time9_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      t1_q       <= t1_d;
      q2_q       <= day_prod[56:38];
      t2_q       <= t1_q;
      days3_q    <= days3_d;
      sod3_q     <= {rem_lo, t2_q[6:0]};
      hour4_q    <= hour_prod[25:21];
      sod4_q     <= sod3_q;
      rem5_q     <= rem5_d;
      hour5_q    <= hour4_q;
      min6_q     <= min_prod[19:14];
      rem6_q     <= rem5_q;
      hour6_q    <= hour5_q;
      time7_q    <= {hour6_q, min6_q, sec7[5:1]};
      time8_q    <= time7_q;
      time9_q    <= time8_q;
      dos_date_q <= dos_date_d;
      dos_time_q <= dos_time_d;
    end
  end

  assign out_o.valid    = valid_q[NumStages-1];
  assign out_o.dos_date = dos_date_q;
  assign out_o.dos_time = dos_time_q;

endmodule

// ===== hw/rtl/utdd_date_pipe.sv =====
// Six-stage pipeline from days since 1970 to a proleptic Gregorian year, month and day.
// Depends on utdd_pkg.
module utdd_date_pipe import utdd_pkg::*; (
  input  logic  clk_i,
  input  logic  en_i,
  input  days_t days_i,
  output date_t date_o
);

  logic [20:0] z1;
  logic [2:0]  era1;
  logic [17:0] doe1_d;
  logic [17:0] doe1_q;
  logic [2:0]  era1_q;

  logic [32:0] cent_prod;
  logic [2:0]  quad_cnt;
  logic [17:0] adj2_d;
  logic [17:0] adj2_q;
  logic [17:0] doe2_q;
  logic [2:0]  era2_q;

  logic [36:0] yoe_prod;
  logic [8:0]  yoe3_q;
  logic [17:0] doe3_q;
  logic [2:0]  era3_q;

  logic [1:0]  cent_cnt;
  logic [17:0] yr_days;
  logic [8:0]  doy4_d;
  logic [8:0]  doy4_q;
  logic [8:0]  yoe4_q;
  logic [2:0]  era4_q;

  logic [10:0] mp_num;
  logic [22:0] mp_prod;
  logic [3:0]  mp5_q;
  logic [8:0]  doy5_q;
  logic [8:0]  yoe5_q;
  logic [2:0]  era5_q;

  logic [8:0]  day_full;
  logic [3:0]  month6;
  date_t       date_d;
  date_t       date_q;

  always_comb begin
    z1   = 21'(days_i) + 21'd719468;
    era1 = '0;
    for (int k = 1; k < 8; k++) begin
      if (z1 >= era_base(3'(k))) begin
        era1 = era1 + 3'd1;
      end
    end
    doe1_d = 18'(z1 - era_base(era1));
  end

  always_comb begin
    cent_prod = 33'(doe1_q[17:2]) * 33'd91930;
    quad_cnt  = 3'(doe1_q >= 18'd36524) + 3'(doe1_q >= 18'd73048)
              + 3'(doe1_q >= 18'd109572) + 3'(doe1_q >= 18'd146096);
    adj2_d    = doe1_q - 18'(cent_prod[31:25]) + 18'(quad_cnt)
              - 18'(doe1_q == 18'd146096);
  end

  assign yoe_prod = 37'(adj2_q) * 37'd367720;

  always_comb begin
    cent_cnt = 2'(yoe3_q >= 9'd100) + 2'(yoe3_q >= 9'd200) + 2'(yoe3_q >= 9'd300);
    yr_days  = 18'(18'(yoe3_q) * 18'd365) + 18'(yoe3_q[8:2]) - 18'(cent_cnt);
    doy4_d   = 9'(doe3_q - yr_days);
  end

  always_comb begin
    mp_num  = 11'(11'(doy4_q) * 11'd5) + 11'd2;
    mp_prod = 23'(mp_num) * 23'd3427;
  end

  always_comb begin
    day_full    = doy5_q - month_offset(mp5_q) + 9'd1;
    month6      = (mp5_q < 4'd10) ? (mp5_q + 4'd3) : (mp5_q - 4'd9);
    date_d.day   = day_full[4:0];
    date_d.month = month6;
    date_d.year  = 12'(yoe5_q) + 12'(12'(era5_q) * 12'd400) + 12'(month6 <= 4'd2);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      doe1_q <= doe1_d;
      era1_q <= era1;
      adj2_q <= adj2_d;
      doe2_q <= doe1_q;
      era2_q <= era1_q;
      yoe3_q <= yoe_prod[35:27];
      doe3_q <= doe2_q;
      era3_q <= era2_q;
      doy4_q <= doy4_d;
      yoe4_q <= yoe3_q;
      era4_q <= era3_q;
      mp5_q  <= mp_prod[22:19];
      doy5_q <= doy4_q;
      yoe5_q <= yoe4_q;
      era5_q <= era4_q;
      date_q <= date_d;
    end
  end

  assign date_o = date_q;

endmodule
